// File: src/bpr_pkg.sv
// bpr_pkg: shared types, register indexes and constant tables for the
// bitfield pixel to rgba converter. Used by every module under src except bpr_port_checker.
package bpr_pkg;

  localparam int NUM_CHAN = 4;
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_ALPHA = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD   = 3'd4;

  localparam logic [4:0] WIDTH_MAX = 5'd16;

  typedef enum logic [2:0] {
    DEPTH_1,
    DEPTH_2,
    DEPTH_4,
    DEPTH_8,
    DEPTH_16,
    DEPTH_24,
    DEPTH_32,
    DEPTH_64
  } depth_t;

  typedef struct packed {
    logic [4:0] width;
    logic [5:0] shift;
  } chan_t;

  typedef struct packed {
    depth_t               depth;
    chan_t [NUM_CHAN-1:0] chan;
  } pix_cfg_t;

  // per-stage load enables of the pipeline
  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic ld_c;
    logic ld_d;
  } pipe_ld_t;

  function automatic chan_t make_chan(input logic [4:0] w, input logic [5:0] s);
    chan_t c;
    c.width = w;
    c.shift = s;
    return c;
  endfunction

  // (2^w)-1 for w in 0..16
  function automatic logic [15:0] chan_mask(input logic [4:0] w);
    logic [16:0] m;
    m = (17'd1 << w) - 17'd1;
    return m[15:0];
  endfunction

  // floor(2^24 / (2^w - 1)), zero for an absent channel
  function automatic logic [24:0] recip(input logic [4:0] w);
    logic [24:0] r;
    case (w)
      5'd1:    r = 25'd16777216;
      5'd2:    r = 25'd5592405;
      5'd3:    r = 25'd2396745;
      5'd4:    r = 25'd1118481;
      5'd5:    r = 25'd541200;
      5'd6:    r = 25'd266305;
      5'd7:    r = 25'd132104;
      5'd8:    r = 25'd65793;
      5'd9:    r = 25'd32832;
      5'd10:   r = 25'd16400;
      5'd11:   r = 25'd8196;
      5'd12:   r = 25'd4097;
      5'd13:   r = 25'd2048;
      5'd14:   r = 25'd1024;
      5'd15:   r = 25'd512;
      5'd16:   r = 25'd256;
      default: r = 25'd0;
    endcase
    return r;
  endfunction

endpackage

// File: src/bpr_cfg.sv
// bpr_cfg: configuration registers and the registered layout decode
// (storage depth, channel widths and shifts, default layouts). Uses bpr_pkg.
module bpr_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output bpr_pkg::pix_cfg_t                 pcfg
);
  import bpr_pkg::*;

  logic [10:0] red_field;
  logic [10:0] green_field;
  logic [10:0] blue_field;
  logic [10:0] alpha_field;
  logic [6:0]  padding_extent;

  logic [10:0] fld [NUM_CHAN];
  chan_t [NUM_CHAN-1:0] user_chan;
  logic [6:0]  reach [NUM_CHAN];
  logic [6:0]  ext;
  logic        none;
  logic [4:0]  gray_w;
  pix_cfg_t    pcfg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_field      <= '0;
      green_field    <= '0;
      blue_field     <= '0;
      alpha_field    <= '0;
      padding_extent <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RED:   red_field      <= cfg_wdata;
        REG_GREEN: green_field    <= cfg_wdata;
        REG_BLUE:  blue_field     <= cfg_wdata;
        REG_ALPHA: alpha_field    <= cfg_wdata;
        REG_PAD:   padding_extent <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign fld[CH_RED]   = red_field;
  assign fld[CH_GREEN] = green_field;
  assign fld[CH_BLUE]  = blue_field;
  assign fld[CH_ALPHA] = alpha_field;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      user_chan[c].width = (fld[c][4:0] > WIDTH_MAX) ? WIDTH_MAX : fld[c][4:0];
      user_chan[c].shift = fld[c][10:5];
      reach[c] = (user_chan[c].width == 5'd0) ? 7'd0
               : 7'(user_chan[c].shift) + 7'(user_chan[c].width);
    end

    ext = padding_extent;
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (reach[c] > ext) ext = reach[c];
    end

    none = (user_chan[CH_RED].width == 5'd0) && (user_chan[CH_GREEN].width == 5'd0) &&
           (user_chan[CH_BLUE].width == 5'd0) && (user_chan[CH_ALPHA].width == 5'd0);

    if (ext <= 7'd1)       pcfg_next.depth = DEPTH_1;
    else if (ext <= 7'd2)  pcfg_next.depth = DEPTH_2;
    else if (ext <= 7'd4)  pcfg_next.depth = DEPTH_4;
    else if (ext <= 7'd8)  pcfg_next.depth = DEPTH_8;
    else if (ext <= 7'd16) pcfg_next.depth = DEPTH_16;
    else if (ext <= 7'd24) pcfg_next.depth = DEPTH_24;
    else if (ext <= 7'd32) pcfg_next.depth = DEPTH_32;
    else                   pcfg_next.depth = DEPTH_64;

    pcfg_next.chan = user_chan;
    gray_w = 5'd0;

    if (none) begin
      case (pcfg_next.depth)
        DEPTH_1: gray_w = 5'd1;
        DEPTH_2: gray_w = 5'd2;
        DEPTH_4: gray_w = 5'd4;
        DEPTH_8: begin
          pcfg_next.chan[CH_RED]   = make_chan(5'd3, 6'd5);
          pcfg_next.chan[CH_GREEN] = make_chan(5'd3, 6'd2);
          pcfg_next.chan[CH_BLUE]  = make_chan(5'd2, 6'd0);
        end
        DEPTH_16: begin
          pcfg_next.chan[CH_RED]   = make_chan(5'd5, 6'd11);
          pcfg_next.chan[CH_GREEN] = make_chan(5'd6, 6'd5);
          pcfg_next.chan[CH_BLUE]  = make_chan(5'd5, 6'd0);
        end
        DEPTH_24: begin
          pcfg_next.chan[CH_RED]   = make_chan(5'd8, 6'd16);
          pcfg_next.chan[CH_GREEN] = make_chan(5'd8, 6'd8);
          pcfg_next.chan[CH_BLUE]  = make_chan(5'd8, 6'd0);
        end
        DEPTH_32: begin
          pcfg_next.chan[CH_RED]   = make_chan(5'd8, 6'd16);
          pcfg_next.chan[CH_GREEN] = make_chan(5'd8, 6'd8);
          pcfg_next.chan[CH_BLUE]  = make_chan(5'd8, 6'd0);
          pcfg_next.chan[CH_ALPHA] = make_chan(5'd8, 6'd24);
        end
        default: ;
      endcase
      // sub-byte gray: the whole pixel value drives r, g and b
      if (gray_w != 5'd0) begin
        pcfg_next.chan[CH_RED]   = make_chan(gray_w, 6'd0);
        pcfg_next.chan[CH_GREEN] = make_chan(gray_w, 6'd0);
        pcfg_next.chan[CH_BLUE]  = make_chan(gray_w, 6'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    pcfg <= pcfg_next;
  end

endmodule

// File: src/bpr_unpack.sv
// bpr_unpack: input capture stage, then pixel selection by depth and
// extraction of the four channel fields. Uses bpr_pkg.
module bpr_unpack (
  input  logic                                   clk,
  input  bpr_pkg::pipe_ld_t                      ld,
  input  bpr_pkg::pix_cfg_t                      pcfg,
  input  logic [31:0]                            raw_data,
  input  logic [2:0]                             sub_index,
  output logic [bpr_pkg::NUM_CHAN-1:0][15:0]     val,
  output logic [bpr_pkg::NUM_CHAN-1:0][4:0]      width
);
  import bpr_pkg::*;

  logic [31:0] raw_q;
  logic [2:0]  sub_q;
  logic [31:0] pix;
  logic [7:0]  pair;
  logic [31:0] shifted [NUM_CHAN];
  logic [NUM_CHAN-1:0][15:0] val_next;

  always_ff @(posedge clk) begin
    if (ld.ld_a) begin
      raw_q <= raw_data;
      sub_q <= sub_index;
    end
  end

  always_comb begin
    // position 0 is the most significant pixel of the byte
    pair = raw_q[7:0] >> {~sub_q[1:0], 1'b0};
    case (pcfg.depth)
      DEPTH_1:  pix = {31'd0, raw_q[~sub_q]};
      DEPTH_2:  pix = {30'd0, pair[1:0]};
      DEPTH_4:  pix = sub_q[0] ? {28'd0, raw_q[3:0]} : {28'd0, raw_q[7:4]};
      DEPTH_8:  pix = {24'd0, raw_q[7:0]};
      DEPTH_16: pix = {16'd0, raw_q[15:0]};
      DEPTH_24: pix = {8'd0, raw_q[23:0]};
      DEPTH_32: pix = raw_q;
      default:  pix = 32'd0;
    endcase

    for (int c = 0; c < NUM_CHAN; c++) begin
      shifted[c]  = pix >> pcfg.chan[c].shift;
      val_next[c] = shifted[c][15:0] & chan_mask(pcfg.chan[c].width);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_b) begin
      val <= val_next;
      for (int c = 0; c < NUM_CHAN; c++) begin
        width[c] <= pcfg.chan[c].width;
      end
    end
  end

endmodule

// File: src/bpr_scale.sv
// bpr_scale: two-stage scaling of one channel to 0..255 as
// val*255/(2^w-1): reciprocal multiply, then remainder correction. Uses bpr_pkg.
module bpr_scale (
  input  logic              clk,
  input  bpr_pkg::pipe_ld_t ld,
  input  logic [15:0]       val,
  input  logic [4:0]        width,
  input  logic [7:0]        absent_level,
  output logic [7:0]        level
);
  import bpr_pkg::*;

  logic [23:0] x;
  logic [48:0] prod;
  logic [23:0] x_c;
  logic [7:0]  qe_c;
  logic [4:0]  w_c;
  logic [15:0] m;
  logic [23:0] qm;
  logic [23:0] rem;
  logic [7:0]  q;

  assign x    = {val, 8'h00} - {8'h00, val};
  assign prod = 49'(x) * 49'(recip(width));

  always_ff @(posedge clk) begin
    if (ld.ld_c) begin
      x_c  <= x;
      // estimate is exact or one low
      qe_c <= prod[31:24];
      w_c  <= width;
    end
  end

  assign m   = chan_mask(w_c);
  assign qm  = 24'(qe_c) * 24'(m);
  assign rem = x_c - qm;
  assign q   = (rem >= 24'(m)) ? qe_c + 8'd1 : qe_c;

  always_ff @(posedge clk) begin
    if (ld.ld_d) begin
      level <= (w_c == 5'd0) ? absent_level : q;
    end
  end

endmodule

// File: src/bitfield_pixel_to_rgba.sv
// bitfield_pixel_to_rgba: top level of the packed pixel to rgba8888
// converter; pipeline control around bpr_cfg, bpr_unpack and bpr_scale.
// Depends on bpr_pkg.
//
// Usage:
// - pixel channel: raw_data and sub_index with pixel_valid/pixel_stall; a
//   transaction happens at a clock edge with pixel_valid high and
//   pixel_stall low.
// - rgba channel: red, green, blue, alpha with rgba_valid/rgba_stall.
// - config port: cfg_we, cfg_index, cfg_wdata; write only while no pixel is
//   in flight. A write takes effect for pixels accepted from the next cycle.
// - pipeline: an accepted pixel passes four register stages (capture, field
//   extract, reciprocal multiply, remainder correction with the output
//   register) before it shows on the rgba outputs.
// - throughput: one pixel per cycle unless stalled; up to four pixels in flight.
// - stall: each stage moves when the stage after it is empty or moving, so
//   bubbles close up; pixel_stall rises only when all four stages are full
//   and rgba_stall is high. A stalled result holds its value.
// - reset: clears valid bits and all config registers (no fields, no
//   padding: 1 bpp gray).
module bitfield_pixel_to_rgba (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  logic [31:0]                       raw_data,
  input  logic [2:0]                        sub_index,
  output logic                              rgba_valid,
  input  logic                              rgba_stall,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue,
  output logic [7:0]                        alpha
);
  import bpr_pkg::*;

  pix_cfg_t  pcfg;
  pipe_ld_t  ld;
  logic      a_valid;
  logic      b_valid;
  logic      c_valid;
  logic [NUM_CHAN-1:0][15:0] val;
  logic [NUM_CHAN-1:0][4:0]  width;
  logic [7:0] level [NUM_CHAN];

  always_comb begin
    ld.ld_d = !rgba_valid || !rgba_stall;
    ld.ld_c = !c_valid || ld.ld_d;
    ld.ld_b = !b_valid || ld.ld_c;
    ld.ld_a = !a_valid || ld.ld_b;
  end

  assign pixel_stall = !ld.ld_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      c_valid    <= 1'b0;
      rgba_valid <= 1'b0;
    end else begin
      if (ld.ld_a) a_valid    <= pixel_valid;
      if (ld.ld_b) b_valid    <= a_valid;
      if (ld.ld_c) c_valid    <= b_valid;
      if (ld.ld_d) rgba_valid <= c_valid;
    end
  end

  bpr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pcfg      (pcfg)
  );

  bpr_unpack u_unpack (
    .clk       (clk),
    .ld        (ld),
    .pcfg      (pcfg),
    .raw_data  (raw_data),
    .sub_index (sub_index),
    .val       (val),
    .width     (width)
  );

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    bpr_scale u_scale (
      .clk          (clk),
      .ld           (ld),
      .val          (val[c]),
      .width        (width[c]),
      .absent_level ((c == CH_ALPHA) ? 8'hFF : 8'h00),
      .level        (level[c])
    );
  end

  assign red   = level[CH_RED];
  assign green = level[CH_GREEN];
  assign blue  = level[CH_BLUE];
  assign alpha = level[CH_ALPHA];

endmodule

// File: src/bpr_checker.sv
// bpr_checker: port-level assertions for bitfield_pixel_to_rgba, attached
// by the bind statement at the end of this file. No package dependency.
module bpr_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       pixel_valid,
  input logic       pixel_stall,
  input logic       rgba_valid,
  input logic       rgba_stall,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic [7:0] alpha
);

  // a result waiting under stall stays
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rgba_valid && rgba_stall |=> rgba_valid)
    else $error("rgba transaction dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    rgba_valid && rgba_stall |=> $stable(red) && $stable(green) &&
                                 $stable(blue) && $stable(alpha))
    else $error("rgba payload changed under stall");

  // empty output stage means the whole pipe can move
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rgba_valid |-> !pixel_stall)
    else $error("pixel_stall high with output empty");

  // an accepted pixel reaches the output when rgba_stall stays low
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall && !rgba_stall) ##1 !rgba_stall ##1 !rgba_stall
      ##1 !rgba_stall |=> rgba_valid)
    else $error("pixel did not reach rgba output in time");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !rgba_valid)
    else $error("rgba_valid high after reset");

endmodule

bind bitfield_pixel_to_rgba bpr_port_checker u_bpr_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel_valid),
  .pixel_stall (pixel_stall),
  .rgba_valid  (rgba_valid),
  .rgba_stall  (rgba_stall),
  .red         (red),
  .green       (green),
  .blue        (blue),
  .alpha       (alpha)
);
